@@ rtl/core/u8u2_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8u2_pkg
// Shared types and constants of the UTF-8 to UCS-2 stream decoder.
// ----------------------------------------------------------------------------
package u8u2_pkg;

    // Reset value of the replacement unit: question mark
    localparam logic [15:0] REPL_RESET = 16'h003F;

    // Byte class masks and patterns
    localparam logic [7:0] MASK_2B   = 8'hE0;
    localparam logic [7:0] LEAD_2B   = 8'hC0;
    localparam logic [7:0] MASK_3B   = 8'hF0;
    localparam logic [7:0] LEAD_3B   = 8'hE0;
    localparam logic [7:0] MASK_4B   = 8'hF8;
    localparam logic [7:0] LEAD_4B   = 8'hF0;
    localparam logic [7:0] MASK_5B   = 8'hFC;
    localparam logic [7:0] LEAD_5B   = 8'hF8;
    localparam logic [7:0] MASK_6B   = 8'hFE;
    localparam logic [7:0] LEAD_6B   = 8'hFC;
    localparam logic [7:0] MASK_CONT = 8'hC0;
    localparam logic [7:0] PAT_CONT  = 8'h80;

    // Payload masks of lead bytes
    localparam logic [7:0] PAY_2B = 8'h1F;
    localparam logic [7:0] PAY_3B = 8'h0F;

    // Bytes to skip after a long lead
    localparam logic [2:0] SKIP_4B = 3'd3;
    localparam logic [2:0] SKIP_5B = 3'd4;
    localparam logic [2:0] SKIP_6B = 3'd5;

    // Sequence lengths
    localparam logic [1:0] LEN_2B = 2'd2;
    localparam logic [1:0] LEN_3B = 2'd3;

    // One classified request: errors before, one main unit, errors after
    typedef struct packed {
        logic [1:0]  pre_cnt;
        logic        main_vld;
        logic        main_err;
        logic [15:0] main_unit;
        logic [1:0]  post_cnt;
        logic        last;
    } job_t;

endpackage
`default_nettype wire

@@ rtl/core/u8u2_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8u2_front
// Accepts bytes, tracks the pending sequence, pushes a job per byte with output.
// ----------------------------------------------------------------------------
module u8u2_front (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [7:0]          s_tdata,    // [7:0] byte_in
    input  wire                 s_tlast,    // last_byte
    input  wire                 q_full,
    output logic                job_push,
    output u8u2_pkg::job_t      job
);

    logic [15:0] partial_reg, partial_next;
    logic [1:0]  held_reg, held_next;
    logic [1:0]  needed_reg, needed_next;
    logic [2:0]  skip_reg, skip_next;

    logic [15:0] acc;
    logic [1:0]  held_inc;
    logic        fresh_en;
    logic        accept;
    logic        job_any;

    assign s_tready = ~q_full;
    assign accept   = s_tvalid & s_tready;

    // Classify the byte against the pending state
    always_comb begin
        partial_next = partial_reg;
        held_next    = held_reg;
        needed_next  = needed_reg;
        skip_next    = skip_reg;
        job          = '0;
        job.last     = s_tlast;
        fresh_en     = 1'b0;
        acc          = {partial_reg[9:0], s_tdata[5:0]};
        held_inc     = held_reg + 2'd1;

        if (skip_reg != 3'd0) begin
            skip_next = skip_reg - 3'd1;
        end else if (held_reg != 2'd0) begin
            if ((s_tdata & u8u2_pkg::MASK_CONT) == u8u2_pkg::PAT_CONT) begin
                if (held_inc >= needed_reg) begin
                    job.main_vld  = 1'b1;
                    job.main_unit = acc;
                    partial_next  = '0;
                    held_next     = '0;
                    needed_next   = '0;
                end else begin
                    partial_next = acc;
                    held_next    = held_inc;
                end
            end else begin
                // Broken sequence: one error per held byte, then redo the byte
                job.pre_cnt  = held_reg;
                partial_next = '0;
                held_next    = '0;
                needed_next  = '0;
                fresh_en     = 1'b1;
            end
        end else begin
            fresh_en = 1'b1;
        end

        // Decode a byte with nothing pending
        if (fresh_en) begin
            if (s_tdata[7] == 1'b0) begin
                job.main_vld  = 1'b1;
                job.main_unit = {8'h00, s_tdata};
            end else if ((s_tdata & u8u2_pkg::MASK_2B) == u8u2_pkg::LEAD_2B) begin
                partial_next = {8'h00, s_tdata & u8u2_pkg::PAY_2B};
                held_next    = 2'd1;
                needed_next  = u8u2_pkg::LEN_2B;
            end else if ((s_tdata & u8u2_pkg::MASK_3B) == u8u2_pkg::LEAD_3B) begin
                partial_next = {8'h00, s_tdata & u8u2_pkg::PAY_3B};
                held_next    = 2'd1;
                needed_next  = u8u2_pkg::LEN_3B;
            end else begin
                job.main_vld = 1'b1;
                job.main_err = 1'b1;
                if ((s_tdata & u8u2_pkg::MASK_4B) == u8u2_pkg::LEAD_4B) begin
                    skip_next = u8u2_pkg::SKIP_4B;
                end else if ((s_tdata & u8u2_pkg::MASK_5B) == u8u2_pkg::LEAD_5B) begin
                    skip_next = u8u2_pkg::SKIP_5B;
                end else if ((s_tdata & u8u2_pkg::MASK_6B) == u8u2_pkg::LEAD_6B) begin
                    skip_next = u8u2_pkg::SKIP_6B;
                end
            end
        end

        // End of string: flush what is held and start clean
        if (s_tlast) begin
            job.post_cnt = held_next;
            partial_next = '0;
            held_next    = '0;
            needed_next  = '0;
            skip_next    = '0;
        end
    end

    assign job_any  = (job.pre_cnt != 2'd0) | job.main_vld | (job.post_cnt != 2'd0) | job.last;
    assign job_push = accept & job_any;

    // Advance the sequence state on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            held_reg    <= '0;
            needed_reg  <= '0;
            skip_reg    <= '0;
        end else if (accept) begin
            partial_reg <= partial_next;
            held_reg    <= held_next;
            needed_reg  <= needed_next;
            skip_reg    <= skip_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/u8u2_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8u2_queue
// Two-entry job queue between the byte front and the unit back end.
// ----------------------------------------------------------------------------
module u8u2_queue (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push,
    input  u8u2_pkg::job_t      push_job,
    output logic                full,
    input  wire                 pop,
    output logic                head_vld,
    output u8u2_pkg::job_t      head_job
);

    u8u2_pkg::job_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign head_vld = (count_reg != 2'd0);
    assign head_job = entry_reg[rd_ptr_reg];

    // Update pointers and fill level
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the request
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/u8u2_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8u2_back
// Expands each job into its result units and loads them into the output
// register, one per cycle while m_tready does not stall it.
// ----------------------------------------------------------------------------
module u8u2_back (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire  [15:0]         repl_unit,
    input  wire                 head_vld,
    input  u8u2_pkg::job_t      head_job,
    output logic                pop,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [15:0]         m_tdata,    // [15:0] code_unit
    output logic [2:0]          m_tuser,    // [0] has_unit, [1] was_error, [2] last_of_run
    output logic                m_tlast     // end_of_string
);

    logic [1:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic [15:0] data_reg, data_next;
    logic [2:0]  user_reg, user_next;
    logic        last_reg, last_next;

    logic [1:0]  total;
    logic        marker;
    logic        last_slot;
    logic        is_main;
    logic        good;
    logic        load;

    assign total     = head_job.pre_cnt + {1'b0, head_job.main_vld} + head_job.post_cnt;
    assign marker    = (total == 2'd0);
    assign last_slot = marker | (idx_reg == total - 2'd1);
    assign is_main   = head_job.main_vld & (idx_reg == head_job.pre_cnt);
    assign good      = is_main & ~head_job.main_err;
    assign load      = head_vld & (~valid_reg | m_tready);
    assign pop       = load & last_slot;

    // Build the unit at the current slot
    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            if (marker) begin
                data_next = '0;
            end else if (good) begin
                data_next = head_job.main_unit;
            end else begin
                data_next = repl_unit;
            end
            user_next = {last_slot, ~marker & ~good, ~marker};
            last_next = last_slot & head_job.last;
            idx_next  = last_slot ? 2'd0 : idx_reg + 2'd1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire

@@ rtl/core/utf8_to_ucs2_stream_decoder.sv @@
// The byte path is registered: an accepted byte's job is written into the job
// queue, and its first unit is loaded from the queue head into the output.
// Throughput: one byte per cycle while no byte gives more than one unit and
// m_tready stays high. The output register sends one unit per cycle while
// m_tready is high; the two-entry job queue absorbs bytes giving more units.
// Reset (aresetn low, synchronous): clears sequence state, queue and output
// valid, and sets the replacement unit to 0x003F.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_ucs2_stream_decoder
// Decodes a byte stream of UTF-8 text into 16-bit UCS-2 code units.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_stream_decoder (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // [7:0] byte_in
    input  wire         s_tlast,    // last_byte
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,    // [15:0] code_unit
    output logic [2:0]  m_tuser,    // [0] has_unit, [1] was_error, [2] last_of_run
    output logic        m_tlast,    // end_of_string
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [15:0] cfg_data    // [15:0] replacement_unit
);

    logic [15:0]     repl_reg;
    logic            q_full;
    logic            job_push;
    u8u2_pkg::job_t  job;
    logic            pop;
    logic            head_vld;
    u8u2_pkg::job_t  head_job;

    assign cfg_ready = 1'b1;

    // Hold the replacement unit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repl_reg <= u8u2_pkg::REPL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            repl_reg <= cfg_data;
        end
    end

    u8u2_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .job_push (job_push),
        .job      (job)
    );

    u8u2_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (job),
        .full     (q_full),
        .pop      (pop),
        .head_vld (head_vld),
        .head_job (head_job)
    );

    u8u2_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .repl_unit (repl_reg),
        .head_vld  (head_vld),
        .head_job  (head_job),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

@@ rtl/core/u8u2_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8u2_checker
// Port-level checks of the decoder's result stream.
// ----------------------------------------------------------------------------
module u8u2_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [15:0] m_tdata,
    input wire [2:0]  m_tuser,
    input wire        m_tlast
);

    // End of string always closes the run of its byte
    a_eos_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[2])
        else $error("end of string without last of run");

    // An end marker carries nothing and closes the string
    a_marker_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 16'h0000 && !m_tuser[1]
                                    && m_tuser[2] && m_tlast)
        else $error("malformed end marker");

    // An error unit is a real unit
    a_err_has_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("error flag on a marker");

    // A stalled request holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed under stall");

endmodule

bind utf8_to_ucs2_stream_decoder u8u2_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

@@ tb/utf8_to_ucs2_stream_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_ucs2_stream_decoder_tb
// Streams UTF-8 strings into the decoder and predicts every UCS-2 unit, error
// replacement and end marker it should return. The first strings walk through
// the corner cases. Random strings follow in several phases, each with its own
// replacement unit and its own idle pattern on both streams. Every returned
// unit is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_stream_decoder_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int PHASE_BYTES    = 42;
    localparam int N_PHASES       = 5;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic [15:0] code_unit;
        logic        has_unit;
        logic        was_error;
        logic        last_of_run;
        logic        end_of_string;
    } unit_result_t;

    // Predicts the units of each accepted byte and checks the returned units
    class ucs2_unit_tracker;
        logic [15:0]  replacement;
        logic [15:0]  partial;
        logic [1:0]   held;
        logic [1:0]   needed;
        logic [2:0]   skip_left;
        unit_result_t expected_units[$];
        unit_result_t step_units[3];
        int           step_count;
        int           mismatches;
        int           units_checked;
        int           replacements_seen;
        int           markers_seen;

        function new();
            replacement       = u8u2_pkg::REPL_RESET;
            partial           = '0;
            held              = '0;
            needed            = '0;
            skip_left         = '0;
            step_count        = 0;
            mismatches        = 0;
            units_checked     = 0;
            replacements_seen = 0;
            markers_seen      = 0;
        endfunction

        function void set_replacement(logic [15:0] unit);
            replacement = unit;
        endfunction

        // One byte never gives more than three units
        function void emit(logic [15:0] unit, logic has, logic err);
            unit_result_t r;
            if (step_count < 3) begin
                r.code_unit     = unit;
                r.has_unit      = has;
                r.was_error     = err;
                r.last_of_run   = 1'b0;
                r.end_of_string = 1'b0;
                step_units[step_count] = r;
                step_count++;
            end
        endfunction

        // Drop the pending sequence, one replacement per byte held
        function void flush_held();
            for (int k = 0; k < held; k++)
                emit(replacement, 1'b1, 1'b1);
            held    = '0;
            needed  = '0;
            partial = '0;
        endfunction

        // Classify a byte with no sequence pending
        function void decode_fresh(logic [7:0] b);
            if (b < 8'h80) begin
                emit({8'h00, b}, 1'b1, 1'b0);
            end else if ((b & u8u2_pkg::MASK_2B) == u8u2_pkg::LEAD_2B) begin
                partial = {8'h00, b & u8u2_pkg::PAY_2B};
                held    = 2'd1;
                needed  = u8u2_pkg::LEN_2B;
            end else if ((b & u8u2_pkg::MASK_3B) == u8u2_pkg::LEAD_3B) begin
                partial = {8'h00, b & u8u2_pkg::PAY_3B};
                held    = 2'd1;
                needed  = u8u2_pkg::LEN_3B;
            end else if ((b & u8u2_pkg::MASK_4B) == u8u2_pkg::LEAD_4B) begin
                emit(replacement, 1'b1, 1'b1);
                skip_left = u8u2_pkg::SKIP_4B;
            end else if ((b & u8u2_pkg::MASK_5B) == u8u2_pkg::LEAD_5B) begin
                emit(replacement, 1'b1, 1'b1);
                skip_left = u8u2_pkg::SKIP_5B;
            end else if ((b & u8u2_pkg::MASK_6B) == u8u2_pkg::LEAD_6B) begin
                emit(replacement, 1'b1, 1'b1);
                skip_left = u8u2_pkg::SKIP_6B;
            end else begin
                emit(replacement, 1'b1, 1'b1);
            end
        endfunction

        function void predict_units(logic [7:0] b, logic last);
            step_count = 0;
            if (skip_left != 0) begin
                skip_left = skip_left - 3'd1;
            end else if (held != 0) begin
                if ((b & u8u2_pkg::MASK_CONT) == u8u2_pkg::PAT_CONT) begin
                    partial = {partial[9:0], b[5:0]};
                    held    = held + 2'd1;
                    if (held >= needed) begin
                        emit(partial, 1'b1, 1'b0);
                        held    = '0;
                        needed  = '0;
                        partial = '0;
                    end
                end else begin
                    flush_held();
                    decode_fresh(b);
                end
            end else begin
                decode_fresh(b);
            end
            // String end: flush, abandon any skip, mark a silent last byte
            if (last) begin
                flush_held();
                skip_left = '0;
                if (step_count == 0)
                    emit(16'h0000, 1'b0, 1'b0);
            end
            if (step_count > 0) begin
                step_units[step_count-1].last_of_run   = 1'b1;
                step_units[step_count-1].end_of_string = last;
            end
            for (int k = 0; k < step_count; k++)
                expected_units = {expected_units, step_units[k]};
        endfunction

        function void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
            if (got_v !== want_v) begin
                $error("%s mismatch: expected %0h, actual %0h", name, want_v, got_v);
                mismatches++;
            end
        endfunction

        function void check_unit(logic [15:0] data, logic [2:0] user, logic tlast);
            unit_result_t want;
            units_checked++;
            if (expected_units.size() == 0) begin
                $error("unit %04h returned with no request pending", data);
                mismatches++;
                return;
            end
            want = expected_units.pop_front();
            if (want.has_unit && want.was_error)
                replacements_seen++;
            if (!want.has_unit)
                markers_seen++;
            compare_field("code_unit", want.code_unit, data);
            compare_field("has_unit", want.has_unit, user[0]);
            compare_field("was_error", want.was_error, user[1]);
            compare_field("last_of_run", want.last_of_run, user[2]);
            compare_field("end_of_string", want.end_of_string, tlast);
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = 16'h0000;

    ucs2_unit_tracker tracker;
    int s_gap_max    = 2;
    int m_stall_max  = 2;
    int idle_cycles  = 0;
    int bytes_sent   = 0;
    int strings_sent = 0;

    utf8_to_ucs2_stream_decoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Hold off or accept units at random
    initial begin
        int n;
        wait (aresetn === 1'b1);
        forever begin
            n = $urandom_range(0, m_stall_max);
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid === 1'b1 && m_tready));
        end
    end

    // Check each accepted unit
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready)
            tracker.check_unit(m_tdata, m_tuser, m_tlast);
    end

    // End the run if no request moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready) ||
            (cfg_valid && cfg_ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = $urandom_range(0, s_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        tracker.predict_units(b, last);
        bytes_sent++;
    endtask

    task automatic send_text(input byte_q_t text);
        for (int k = 0; k < text.size(); k++)
            send_byte(text[k], k == text.size() - 1);
        strings_sent++;
    endtask

    // Wait until every predicted unit is back and the decoder has settled
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tracker.expected_units.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_replacement(input logic [15:0] unit);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= unit;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        tracker.set_replacement(unit);
    endtask

    // Continuation byte, now and then a broken one
    function automatic logic [7:0] cont_byte();
        if ($urandom_range(0, 11) == 0)
            return 8'($urandom_range(0, 255));
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // Mostly well-formed characters with random payload, some noise
    function automatic void build_text(output byte_q_t text);
        int n_chars;
        int kind;
        int n_skip;
        text = {};
        n_chars = $urandom_range(1, 8);
        for (int c = 0; c < n_chars; c++) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                text = {text, 8'($urandom_range(0, 127))};
            end else if (kind < 60) begin
                text = {text, u8u2_pkg::LEAD_2B | 8'($urandom_range(0, 31))};
                text = {text, cont_byte()};
            end else if (kind < 80) begin
                text = {text, u8u2_pkg::LEAD_3B | 8'($urandom_range(0, 15))};
                text = {text, cont_byte()};
                text = {text, cont_byte()};
            end else if (kind < 87) begin
                case ($urandom_range(0, 2))
                    0: begin
                        text   = {text, u8u2_pkg::LEAD_4B | 8'($urandom_range(0, 7))};
                        n_skip = u8u2_pkg::SKIP_4B;
                    end
                    1: begin
                        text   = {text, u8u2_pkg::LEAD_5B | 8'($urandom_range(0, 3))};
                        n_skip = u8u2_pkg::SKIP_5B;
                    end
                    default: begin
                        text   = {text, u8u2_pkg::LEAD_6B | 8'($urandom_range(0, 1))};
                        n_skip = u8u2_pkg::SKIP_6B;
                    end
                endcase
                repeat (n_skip) text = {text, 8'($urandom_range(0, 255))};
            end else begin
                text = {text, 8'($urandom_range(0, 255))};
            end
        end
        // Cut some strings short inside a sequence
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 2))
                if (text.size() > 1) void'(text.pop_back());
        end
    endfunction

    initial begin
        byte_q_t text;
        int      phase_bytes;
        tracker = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ASCII extremes, two- and three-byte characters, silent-free end
        text = {8'h41, 8'h00, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'h7F};
        send_text(text);
        // Stray bytes, broken continuations, end with a sequence pending
        text = {8'h80, 8'hFE, 8'hFF, 8'hC3, 8'h41, 8'hE2, 8'h82, 8'hC3, 8'hA9,
                8'hE2, 8'h82};
        send_text(text);
        // Four-byte lead with skip, six-byte lead abandoned at string end
        text = {8'hF0, 8'h90, 8'h80, 8'h80, 8'hFC, 8'hBF};
        send_text(text);
        // Five-byte lead, last byte swallowed by the skip
        text = {8'hF8, 8'hFF};
        send_text(text);

        // Random strings, one replacement unit and idle pattern per phase
        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0: begin
                    write_replacement(16'h0000);
                    s_gap_max   = 6;
                    m_stall_max = 6;
                end
                1: begin
                    write_replacement(16'hFFFF);
                    s_gap_max   = 0;
                    m_stall_max = 0;
                end
                2: begin
                    write_replacement(16'($urandom_range(0, 65535)));
                    s_gap_max   = 6;
                    m_stall_max = 0;
                end
                3: begin
                    write_replacement(16'($urandom_range(0, 65535)));
                    s_gap_max   = 0;
                    m_stall_max = 6;
                end
                default: begin
                    write_replacement(u8u2_pkg::REPL_RESET);
                    s_gap_max   = 3;
                    m_stall_max = 3;
                end
            endcase
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                build_text(text);
                send_text(text);
                phase_bytes += text.size();
            end
        end

        wait_drained();
        $display("sent %0d bytes in %0d strings over %0d replacement settings",
                 bytes_sent, strings_sent, N_PHASES + 1);
        $display("checked %0d units: %0d replacements, %0d end markers",
                 tracker.units_checked, tracker.replacements_seen, tracker.markers_seen);
        if (tracker.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
